// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ring allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active-low reset).
`define VRRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked check that also holds during reset.
`define VRRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/vrra_pkg.sv =====
// Package for the variable record ring allocator: mode and status codes,
// decoded operation, controller state type and the controller command struct.
// No dependencies.
`timescale 1ns / 1ps

package vrra_pkg;

    localparam int MODE_W   = 3;
    localparam int COUNT_W  = 11;
    localparam int OFFSET_W = 10;
    localparam int STATUS_W = 2;

    // Request modes on the input channel
    localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMMIT_WR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COMMIT_RD = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_DATA  = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ALLOC,
        OP_COMMIT_WR,
        OP_PEEK,
        OP_READ,
        OP_COMMIT_RD
    } t_op;

    // Output register occupancy
    typedef enum logic {
        S_EMPTY,
        S_FULL
    } t_state;

    typedef struct packed {
        logic load;   // item accepted this cycle: update state, load result
        t_op  op;
    } t_cmd;

endpackage

// ===== rtl/core/vrra_ctrl.sv =====
// Controller of the ring allocator: input/output handshake, result register
// occupancy and mode decode. Depends on vrra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vrra_ctrl
    import vrra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_cmd              o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Result register can be refilled in the same cycle it drains
    assign o_in_stall = (r_state == S_FULL) && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EMPTY: begin
                if (accept) begin
                    n_state = S_FULL;
                end
            end
            S_FULL: begin
                if (accept) begin
                    n_state = S_FULL;
                end else if (!i_out_stall) begin
                    n_state = S_EMPTY;
                end
            end
            default: begin
                n_state = S_EMPTY;
            end
        endcase
    end

    always_comb begin
        o_out_valid = (r_state == S_FULL);
        o_cmd.load  = accept;
        unique case (i_mode)
            MODE_ALLOC:     o_cmd.op = OP_ALLOC;
            MODE_COMMIT_WR: o_cmd.op = OP_COMMIT_WR;
            MODE_PEEK:      o_cmd.op = OP_PEEK;
            MODE_READ:      o_cmd.op = OP_READ;
            MODE_COMMIT_RD: o_cmd.op = OP_COMMIT_RD;
            default:        o_cmd.op = OP_NONE;
        endcase
    end

    `VRRA_ASSERT(a_load_gives_result, i_clk, i_rst_n, o_cmd.load |=> o_out_valid, "accepted item produced no result")

endmodule

// ===== rtl/core/vrra_dp.sv =====
// Datapath of the ring allocator: indices, pending counts, credit counts and
// the result register. Depends on vrra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vrra_dp
    import vrra_pkg::*;
#(
    parameter int RING_BLOCKS = 1024
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [COUNT_W-1:0]  i_block_count,
    output logic [OFFSET_W-1:0] o_offset,
    output logic [STATUS_W-1:0] o_status
);

    // Every count and index stays within 0..RING_BLOCKS
    localparam int CW = $clog2(RING_BLOCKS + 1);
    // Arithmetic width: holds RING_BLOCKS plus a full block_count
    localparam int AW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
    localparam logic [AW-1:0] RING_A = AW'(RING_BLOCKS);
    localparam logic [CW-1:0] RING_C = CW'(RING_BLOCKS);

    logic [CW-1:0] r_write_index, n_write_index;
    logic [CW-1:0] r_read_index,  n_read_index;
    logic [CW-1:0] r_wrap_index,  n_wrap_index;
    logic [CW-1:0] r_pend_wr,     n_pend_wr;
    logic [CW-1:0] r_pend_rd,     n_pend_rd;
    logic [CW-1:0] r_peeked,      n_peeked;
    logic [CW-1:0] r_free,        n_free;
    logic [CW-1:0] r_filled,      n_filled;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [STATUS_W-1:0] r_status, n_status;

    logic [AW-1:0] cnt;
    logic [AW-1:0] left;
    logic          wraps;
    logic [AW-1:0] need;
    logic          alloc_ok;
    logic          over_peek;
    logic [AW-1:0] extra;
    logic          data_ok;
    logic          rd_wrap;
    logic [AW-1:0] rd_base;
    logic [AW-1:0] pend_rd_base;
    logic [AW-1:0] rd_end;
    logic [AW-1:0] rel_sum;
    logic [CW-1:0] off_idx;
    logic [31:0]   off_wide;

    always_comb begin
        cnt   = AW'(i_block_count);
        left  = RING_A - AW'(r_write_index);
        wraps = left < cnt;
        need  = wraps ? (left + cnt) : cnt;
        alloc_ok = (cnt <= RING_A) && (need <= AW'(r_free));

        over_peek = cnt > AW'(r_peeked);
        extra     = cnt - AW'(r_peeked);
        data_ok   = !(over_peek && (extra > AW'(r_filled)));

        // Reader passes the wrap point: hand back the skipped tail
        rd_wrap      = r_read_index >= r_wrap_index;
        rd_base      = rd_wrap ? '0 : AW'(r_read_index);
        pend_rd_base = rd_wrap ? (AW'(r_pend_rd) + RING_A - AW'(r_wrap_index))
                               : AW'(r_pend_rd);
        rd_end       = rd_base + cnt;
        rel_sum      = AW'(r_free) + AW'(r_pend_rd);
    end

    always_comb begin
        n_write_index = r_write_index;
        n_read_index  = r_read_index;
        n_wrap_index  = r_wrap_index;
        n_pend_wr     = r_pend_wr;
        n_pend_rd     = r_pend_rd;
        n_peeked      = r_peeked;
        n_free        = r_free;
        n_filled      = r_filled;
        n_status      = STATUS_OK;
        off_idx       = '0;

        case (i_cmd.op)
            OP_ALLOC: begin
                if (!alloc_ok) begin
                    n_status = STATUS_NO_SPACE;
                end else begin
                    n_free = CW'(AW'(r_free) - need);
                    if (wraps) begin
                        n_wrap_index  = r_write_index;
                        n_write_index = CW'(cnt);
                        off_idx       = '0;
                    end else begin
                        n_write_index = CW'(AW'(r_write_index) + cnt);
                        off_idx       = r_write_index;
                    end
                    n_pend_wr = CW'(AW'(r_pend_wr) + cnt);
                end
            end
            OP_COMMIT_WR: begin
                n_filled  = CW'(AW'(r_filled) + AW'(r_pend_wr));
                n_pend_wr = '0;
            end
            OP_PEEK: begin
                if (!data_ok) begin
                    n_status = STATUS_NO_DATA;
                end else begin
                    if (over_peek) begin
                        n_filled = CW'(AW'(r_filled) - extra);
                        n_peeked = CW'(cnt);
                    end
                    if (rd_wrap) begin
                        n_read_index = '0;
                        n_wrap_index = RING_C;
                    end
                    n_pend_rd = CW'(pend_rd_base);
                    off_idx   = CW'(rd_base);
                end
            end
            OP_READ: begin
                if (!data_ok) begin
                    n_status = STATUS_NO_DATA;
                end else begin
                    if (over_peek) begin
                        n_filled = CW'(AW'(r_filled) - extra);
                    end
                    if (rd_wrap) begin
                        n_wrap_index = RING_C;
                    end
                    // Read index saturates at the end of the ring
                    n_read_index = (rd_end > RING_A) ? RING_C : CW'(rd_end);
                    n_pend_rd    = CW'(pend_rd_base + cnt);
                    n_peeked     = '0;
                    off_idx      = CW'(rd_base);
                end
            end
            OP_COMMIT_RD: begin
                n_free    = (rel_sum > RING_A) ? RING_C : CW'(rel_sum);
                n_pend_rd = '0;
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase

        off_wide = 32'(off_idx);
        n_offset = off_wide[OFFSET_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_index <= '0;
            r_read_index  <= '0;
            r_wrap_index  <= RING_C;
            r_pend_wr     <= '0;
            r_pend_rd     <= '0;
            r_peeked      <= '0;
            r_free        <= RING_C;
            r_filled      <= '0;
        end else if (i_cmd.load) begin
            r_write_index <= n_write_index;
            r_read_index  <= n_read_index;
            r_wrap_index  <= n_wrap_index;
            r_pend_wr     <= n_pend_wr;
            r_pend_rd     <= n_pend_rd;
            r_peeked      <= n_peeked;
            r_free        <= n_free;
            r_filled      <= n_filled;
        end
    end

    // Result register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_offset <= n_offset;
            r_status <= n_status;
        end
    end

    assign o_offset = r_offset;
    assign o_status = r_status;

    `VRRA_ASSERT(a_free_bound, i_clk, i_rst_n, r_free <= RING_C, "free credits exceed ring size")
    `VRRA_ASSERT(a_index_bound, i_clk, i_rst_n, (r_write_index <= RING_C) && (r_read_index <= RING_C) && (r_wrap_index <= RING_C), "ring index out of range")
    `VRRA_ASSERT(a_fail_holds, i_clk, i_rst_n, (i_cmd.load && (n_status != STATUS_OK)) |=> ($stable(r_free) && $stable(r_filled) && $stable(r_write_index) && $stable(r_read_index)), "failed request changed state")

endmodule

// ===== rtl/core/variable_record_ring_allocator_top.sv =====
// Variable record ring allocator, top level. Depends on vrra_pkg, vrra_ctrl, vrra_dp.
// A result appears in the output register in the cycle after its item is accepted.
// Throughput: 1 item per cycle unless stalled; each item's state updates all at once.
// The input stalls only while the result register is full and the output is stalled.
// Reset (synchronous, active low): indices, pending and filled counts clear, wrap point
// and free count go to the ring size, the result register empties.
`timescale 1ns / 1ps

module variable_record_ring_allocator_top
    import vrra_pkg::*;
#(
    parameter int RING_BLOCKS = 1024
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [COUNT_W-1:0]  i_block_count,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [OFFSET_W-1:0] o_offset,
    output logic [STATUS_W-1:0] o_status
);

    // Controller to datapath: one load strobe per accepted item plus the decoded op
    t_cmd cmd;

    // Handshake, result-register occupancy and mode decode
    vrra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Ring bookkeeping: allocate charges free credits (plus the skipped tail on a
    // wrap), commits move pending counts into credit counts, peek/read charge
    // filled credits beyond what is already peeked.
    vrra_dp #(
        .RING_BLOCKS (RING_BLOCKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_block_count (i_block_count),
        .o_offset      (o_offset),
        .o_status      (o_status)
    );

endmodule
